/* rtl/tcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types and constants of the track crossfade mixer: sample and track
// widths, the divider quotient width and the lane control and result words.
// ----------------------------------------------------------------------------
package tcm_pkg;

    // Frame carries one sample port per lane
    localparam int LANES       = 2;
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_W    = 16;
    localparam int TRACK_W     = 8;
    localparam int LEN_W       = 16;
    // |mix| <= 32768, so the quotient fits in 17 bits
    localparam int QUO_W       = 17;
    localparam int QCNT_W      = $clog2(QUO_W);

    localparam logic [TRACK_W-1:0] NO_TRACK   = 8'hFF;
    localparam logic [LEN_W-1:0]   FADE_RESET = 16'd4800;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Start request, fade length and weights handed to every lane
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] weight_a;
        logic [LEN_W-1:0] weight_b;
    } t_lane_ctl;

    // Lane status and unsigned quotient with its sign
    typedef struct packed {
        logic             busy;
        logic             neg;
        logic [QUO_W-1:0] quo;
    } t_lane_out;

    // Track bookkeeping reported with each output word
    typedef struct packed {
        logic               fade_active;
        logic [TRACK_W-1:0] next_a;
        logic [TRACK_W-1:0] next_b;
    } t_side;

endpackage

/* rtl/tcm_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_lane
// One channel of the crossfade: weighted sum a*wa + b*wb, then a restoring
// divide by the fade length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcm_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcm_pkg::t_lane_ctl   i_ctl,
    input  tcm_pkg::t_sample     i_a,
    input  tcm_pkg::t_sample     i_b,
    output tcm_pkg::t_lane_out   o_res
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_SUM  = 2'd2;
    localparam logic [1:0] L_DIV  = 2'd3;

    localparam int PROD_W = tcm_pkg::SAMPLE_W + tcm_pkg::LEN_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic [1:0]                     r_state;
    logic [tcm_pkg::QCNT_W-1:0]     r_cnt;
    tcm_pkg::t_sample               r_a;
    tcm_pkg::t_sample               r_b;
    logic [tcm_pkg::LEN_W-1:0]      r_wa;
    logic [tcm_pkg::LEN_W-1:0]      r_wb;
    logic [tcm_pkg::LEN_W-1:0]      r_len;
    logic signed [PROD_W-1:0]       r_pa;
    logic signed [PROD_W-1:0]       r_pb;
    logic                           r_neg;
    logic [tcm_pkg::LEN_W-1:0]      r_rem;
    logic [tcm_pkg::QUO_W-1:0]      r_low;
    logic [tcm_pkg::QUO_W-1:0]      r_quo;

    logic signed [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]               mag;
    logic [tcm_pkg::LEN_W:0]        trial;
    logic [tcm_pkg::LEN_W:0]        diff;
    logic                           ge;

    // Sum of both products and its magnitude
    assign sum = {r_pa[PROD_W-1], r_pa} + {r_pb[PROD_W-1], r_pb};
    assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    // One restoring divide step
    assign trial = {r_rem, r_low[tcm_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, r_len};
    assign ge    = (trial >= {1'b0, r_len});

    // Sequence: latch operands, multiply, sum, divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                    if (i_ctl.start) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_state <= L_SUM;
                end
                L_SUM: begin
                    r_state <= L_DIV;
                    r_cnt   <= tcm_pkg::QCNT_W'(tcm_pkg::QUO_W - 1);
                end
                L_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= L_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_ctl.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_wa  <= i_ctl.weight_a;
            r_wb  <= i_ctl.weight_b;
            r_len <= i_ctl.len;
        end
        if (r_state == L_MUL) begin
            r_pa <= PROD_W'(r_a) * PROD_W'($signed({1'b0, r_wa}));
            r_pb <= PROD_W'(r_b) * PROD_W'($signed({1'b0, r_wb}));
        end
        if (r_state == L_SUM) begin
            // magnitude <= 32768 * len, so the top part is below len
            r_neg <= sum[SUM_W-1];
            r_rem <= mag[tcm_pkg::QUO_W +: tcm_pkg::LEN_W];
            r_low <= mag[tcm_pkg::QUO_W-1:0];
            r_quo <= '0;
        end
        if (r_state == L_DIV) begin
            r_rem <= ge ? diff[tcm_pkg::LEN_W-1:0] : trial[tcm_pkg::LEN_W-1:0];
            r_low <= {r_low[tcm_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[tcm_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_res.busy = (r_state != L_IDLE);
    assign o_res.neg  = r_neg;
    assign o_res.quo  = r_quo;

endmodule

/* rtl/tcm_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcm_merge
// Combines the lane quotients (sign, saturation) or the pass-through samples
// into one output word and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module tcm_merge #(
    parameter int CHANNELS = tcm_pkg::CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_use_div,
    input  tcm_pkg::t_sample    i_direct [tcm_pkg::LANES],
    input  tcm_pkg::t_lane_out  i_lane   [tcm_pkg::LANES],
    input  tcm_pkg::t_side      i_side,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output tcm_pkg::t_sample    o_ch     [tcm_pkg::LANES],
    output tcm_pkg::t_side      o_side
);

    localparam int WIDE_W = tcm_pkg::QUO_W + 1;

    logic                         r_valid;
    tcm_pkg::t_sample             r_ch [tcm_pkg::LANES];
    tcm_pkg::t_side               r_side;
    tcm_pkg::t_sample             n_ch [tcm_pkg::LANES];

    // Apply sign, saturate, pick source, silence unused channels
    always_comb begin
        logic signed [WIDE_W-1:0] wide;
        tcm_pkg::t_sample         sat;
        for (int c = 0; c < tcm_pkg::LANES; c++) begin
            wide = i_lane[c].neg ? -$signed({1'b0, i_lane[c].quo})
                                 :  $signed({1'b0, i_lane[c].quo});
            if (wide > WIDE_W'(tcm_pkg::SAMPLE_MAX)) begin
                sat = tcm_pkg::SAMPLE_MAX;
            end else if (wide < WIDE_W'(tcm_pkg::SAMPLE_MIN)) begin
                sat = tcm_pkg::SAMPLE_MIN;
            end else begin
                sat = wide[tcm_pkg::SAMPLE_W-1:0];
            end
            if (c >= CHANNELS) begin
                n_ch[c] = '0;
            end else begin
                n_ch[c] = i_use_div ? sat : i_direct[c];
            end
        end
    end

    // Hold the word while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ch   <= n_ch;
            r_side <= i_side;
        end
    end

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_ch    = r_ch;
    assign o_side  = r_side;

endmodule

/* rtl/track_crossfade_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_crossfade_mixer
// Linear crossfade between two audio tracks, one stereo frame per word.
//
// Input channel (i_in_valid / o_in_stall) carries the play flag, the wanted
// track and one sample per channel of source track a and destination track
// b. Output channel (o_out_valid / i_out_stall) returns the mixed samples,
// the fade flag and the tracks to fetch for the next frame.
// The fade length register is written through i_cfg_we / i_cfg_wdata.
// One frame is processed at a time. A frame that is paused or not fading
// passes its pending result straight to the output register; a fading
// frame first waits for the per-channel serial divider (a multiply and a
// sum step, then 17 quotient bits one per cycle) before its result is
// loaded. The next frame is accepted only once the result is loaded, and a
// load waits while the output register holds a stalled word.
// A finished word waits in the output register while the next frame is
// accepted and processed; a stalled receiver holds that word and the new
// result waits in the lanes or the pending result fields. Reset empties the
// output register, clears any fade and sets the fade length to 4800 frames.
// ----------------------------------------------------------------------------
module track_crossfade_mixer #(
    parameter int CHANNELS = tcm_pkg::CHANNELS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tcm_pkg::LEN_W-1:0]              i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_playing,
    input  logic [tcm_pkg::TRACK_W-1:0]            i_target_track,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0]    i_sample_a_ch0,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0]    i_sample_a_ch1,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0]    i_sample_b_ch0,
    input  logic signed [tcm_pkg::SAMPLE_W-1:0]    i_sample_b_ch1,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tcm_pkg::SAMPLE_W-1:0]    o_out_ch0,
    output logic signed [tcm_pkg::SAMPLE_W-1:0]    o_out_ch1,
    output logic                                   o_fade_active,
    output logic [tcm_pkg::TRACK_W-1:0]            o_next_track_a,
    output logic [tcm_pkg::TRACK_W-1:0]            o_next_track_b
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WAIT = 1'b1;

    localparam int LW = tcm_pkg::LEN_W;
    localparam int TW = tcm_pkg::TRACK_W;

    logic                 r_state;
    logic [LW-1:0]        r_fade_length;
    logic [TW-1:0]        r_cur;
    logic                 r_run;
    logic [TW-1:0]        r_src;
    logic [TW-1:0]        r_dst;
    logic [LW-1:0]        r_pos;
    logic                 r_use_div;
    tcm_pkg::t_sample     r_direct [tcm_pkg::LANES];
    tcm_pkg::t_side       r_side;

    logic [TW-1:0]        n_cur;
    logic                 n_run;
    logic [TW-1:0]        n_src;
    logic [TW-1:0]        n_dst;
    logic [LW-1:0]        n_pos;
    tcm_pkg::t_sample     n_direct [tcm_pkg::LANES];
    tcm_pkg::t_side       n_side;

    logic                 in_accept;
    logic                 starting;
    logic                 run0;
    logic [TW-1:0]        src0;
    logic [TW-1:0]        dst0;
    logic [LW-1:0]        pos0;
    logic [LW-1:0]        pos1;
    logic [LW-1:0]        len;
    logic [LW-1:0]        mix_pos;
    logic                 fading;
    logic                 lanes_busy;
    logic                 merge_load;
    logic                 merge_free;

    tcm_pkg::t_sample     samp_a [tcm_pkg::LANES];
    tcm_pkg::t_sample     samp_b [tcm_pkg::LANES];
    tcm_pkg::t_lane_out   lane_res [tcm_pkg::LANES];
    tcm_pkg::t_sample     out_ch [tcm_pkg::LANES];
    tcm_pkg::t_side       out_side;
    tcm_pkg::t_lane_ctl   lane_ctl;

    assign samp_a[0] = i_sample_a_ch0;
    assign samp_a[1] = i_sample_a_ch1;
    assign samp_b[0] = i_sample_b_ch0;
    assign samp_b[1] = i_sample_b_ch1;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Fade bookkeeping for the frame at the input
    assign len      = (r_fade_length == '0) ? LW'(1) : r_fade_length;
    assign starting = (i_target_track != r_cur) && !r_run;
    assign run0     = r_run || starting;
    assign src0     = starting ? r_cur          : r_src;
    assign dst0     = starting ? i_target_track : r_dst;
    assign pos0     = starting ? '0             : r_pos;
    assign mix_pos  = (pos0 < len) ? pos0 : len;
    assign pos1     = (pos0 < len) ? pos0 + 1'b1 : pos0;
    assign fading   = i_playing && run0;

    // Next track state; a paused frame keeps everything
    always_comb begin
        n_cur = r_cur;
        n_run = r_run;
        n_src = r_src;
        n_dst = r_dst;
        n_pos = r_pos;
        if (i_playing) begin
            if (!run0) begin
                n_cur = i_target_track;
            end else begin
                n_src = src0;
                n_dst = dst0;
                n_pos = pos1;
                if (pos1 >= len) begin
                    n_cur = dst0;
                    n_run = 1'b0;
                end else begin
                    n_run = 1'b1;
                end
            end
        end
    end

    assign n_side.fade_active = n_run;
    assign n_side.next_a      = n_run ? n_src : n_cur;
    assign n_side.next_b      = n_run ? n_dst : tcm_pkg::NO_TRACK;

    // Pass sample a when not fading, silence when paused
    always_comb begin
        for (int c = 0; c < tcm_pkg::LANES; c++) begin
            n_direct[c] = (i_playing && !run0) ? samp_a[c] : '0;
        end
    end

    assign lane_ctl.start    = in_accept && fading;
    assign lane_ctl.len      = len;
    assign lane_ctl.weight_a = len - mix_pos;
    assign lane_ctl.weight_b = mix_pos;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_length <= tcm_pkg::FADE_RESET;
        end else if (i_cfg_we) begin
            r_fade_length <= i_cfg_wdata;
        end
    end

    // Track state and frame sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= tcm_pkg::NO_TRACK;
            r_run   <= 1'b0;
            r_src   <= tcm_pkg::NO_TRACK;
            r_dst   <= tcm_pkg::NO_TRACK;
            r_pos   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_WAIT;
                        r_cur   <= n_cur;
                        r_run   <= n_run;
                        r_src   <= n_src;
                        r_dst   <= n_dst;
                        r_pos   <= n_pos;
                    end
                end
                S_WAIT: begin
                    if (merge_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the frame's pending result fields
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_use_div <= fading;
            r_direct  <= n_direct;
            r_side    <= n_side;
        end
    end

    // Channel lanes; channels past CHANNELS stay silent
    for (genvar c = 0; c < tcm_pkg::LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            tcm_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lane_ctl),
                .i_a     (samp_a[c]),
                .i_b     (samp_b[c]),
                .o_res   (lane_res[c])
            );
        end else begin : g_off
            assign lane_res[c] = '0;
        end
    end

    always_comb begin
        lanes_busy = 1'b0;
        for (int c = 0; c < tcm_pkg::LANES; c++) begin
            lanes_busy = lanes_busy | lane_res[c].busy;
        end
    end

    assign merge_load = (r_state == S_WAIT) && merge_free && !(r_use_div && lanes_busy);

    tcm_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (merge_load),
        .i_use_div (r_use_div),
        .i_direct  (r_direct),
        .i_lane    (lane_res),
        .i_side    (r_side),
        .i_stall   (i_out_stall),
        .o_free    (merge_free),
        .o_valid   (o_out_valid),
        .o_ch      (out_ch),
        .o_side    (out_side)
    );

    assign o_out_ch0      = out_ch[0];
    assign o_out_ch1      = out_ch[1];
    assign o_fade_active  = out_side.fade_active;
    assign o_next_track_a = out_side.next_a;
    assign o_next_track_b = out_side.next_b;

    // Lanes only run while a frame is in flight
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !lanes_busy)
        else $error("lane busy with no frame in flight");

    // An accepted frame always moves to the wait state
    a_accept_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_WAIT))
        else $error("accepted frame did not enter wait state");

    // A fading frame is not loaded while the divider runs
    a_no_early_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_use_div && lanes_busy) |=> (r_state == S_WAIT))
        else $error("result loaded before divide finished");

    // The fade position never runs past the length while fading
    a_start_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_ctl.start |-> (lane_ctl.weight_b <= lane_ctl.len))
        else $error("mix position beyond fade length");

endmodule
